@@ rtl/mctw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctw_pkg: shared types and constants of the message timeout watchdog
// Command codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package mctw_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned MASK_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

    // Request command codes; codes 5 to 7 carry no operation
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_CHECK     = 3'd1,
        CMD_RECEIVE   = 3'd2,
        CMD_CLEAR_ONE = 3'd3,
        CMD_CLEAR_ALL = 3'd4
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2
    } state_t;

    // Result of one pass through the shared compare unit
    typedef struct packed {
        logic [TIME_W-1:0] elapsed;
        logic              expired;
    } cmp_result_t;

endpackage : mctw_pkg

@@ rtl/mctw_elapsed_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctw_elapsed_cmp: shared elapsed-time compare unit
// Forms the wrap-around elapsed time of one channel and tests it against
// that channel's timeout. The sequencer steps it across all channels.
// ----------------------------------------------------------------------------
module mctw_elapsed_cmp
(
    input  logic [mctw_pkg::TIME_W-1:0] now_ms,
    input  logic [mctw_pkg::TIME_W-1:0] last_seen,
    input  logic [mctw_pkg::TMO_W-1:0]  timeout,
    output mctw_pkg::cmp_result_t       result
);
    import mctw_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // Subtract modulo 2^32 so a counter wrap does not disturb the result
    assign elapsed = now_ms - last_seen;

    // Expire only when strictly past the timeout
    assign result.elapsed = elapsed;
    assign result.expired = (elapsed > {{(TIME_W-TMO_W){1'b0}}, timeout});

endmodule : mctw_elapsed_cmp

@@ rtl/multi_channel_message_timeout_watchdog.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel message timeout watchdog
// Keeps a millisecond counter, a last-seen stamp and a fault flag per channel
// and reports the fault state after every command request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command request: tick,
//   check all, receive, clear one or clear all, plus a channel index.
//   Output channel (out_valid / out_stall) returns one result per request:
//   fault mask, faults newly raised by a check, and the selected channel flag.
//   Configuration writes (cfg_we, cfg_index, cfg_data) set the per-channel
//   timeouts in milliseconds; write them only while the block is idle.
// Timing:
//   Tick, receive and clear requests pass from accept through the EMIT
//   state to the output register. A check first runs the SCAN state: one
//   shared subtract-and-compare unit visits one channel per cycle. The block
//   takes no request during a check or while a result waits in the sequencer.
//   A finished result sits in the output register; a new request is accepted
//   while it waits, and the next result is held back until out_stall drops.
// Reset:
//   Counter, stamps and fault flags clear; all timeouts return to 100 ms.
// ----------------------------------------------------------------------------
module multi_channel_message_timeout_watchdog
#(
    parameter int unsigned CHANNELS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [mctw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mctw_pkg::TMO_W-1:0]     cfg_data,
    // command requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mctw_pkg::CMD_W-1:0]     command,
    input  logic [mctw_pkg::CHAN_W-1:0]    channel,
    // results
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mctw_pkg::MASK_W-1:0]    fault_mask,
    output logic [mctw_pkg::MASK_W-1:0]    new_faults,
    output logic                           channel_faulted
);
    import mctw_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNELS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    // State and configuration storage
    logic [TMO_W-1:0]    timeout_reg   [CHANNELS];
    logic [TIME_W-1:0]   last_seen_reg [CHANNELS];
    logic [TIME_W-1:0]   now_reg;
    logic [CHANNELS-1:0] faulted_reg;
    logic [CHANNELS-1:0] raised_reg;

    // Sequencer
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  scan_idx_reg;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  ch_reg;
    logic              ch_ok_reg;

    // Output register
    logic              out_valid_reg;
    logic [MASK_W-1:0] fault_mask_reg;
    logic [MASK_W-1:0] new_faults_reg;
    logic              channel_faulted_reg;

    logic              accept;
    logic              out_free;
    logic              scan_last;
    logic              emit_load;
    logic              in_ch_ok;
    logic [IDX_W-1:0]  in_idx;
    cmp_result_t       cmp;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (scan_idx_reg == LAST_IDX);
    assign in_ch_ok  = ({1'b0, channel} < CH_LIMIT);
    assign in_idx    = channel[IDX_W-1:0];

    // Shared compare unit, stepped over the channels during a check
    mctw_elapsed_cmp u_cmp
    (
        .now_ms    (now_reg),
        .last_seen (last_seen_reg[scan_idx_reg]),
        .timeout   (timeout_reg[scan_idx_reg]),
        .result    (cmp)
    );

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequencer and drive its strobes
    always_comb
    begin
        state_next = state_reg;
        emit_load  = 1'b0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (command == CMD_CHECK) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Write timeouts; writes beyond the channel count are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                timeout_reg[i] <= TIMEOUT_RESET;
            end
        end
        else if (cfg_we && ({1'b0, cfg_index} < CH_LIMIT))
        begin
            timeout_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    // Latch the request, execute the single-step commands and step the check scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            faulted_reg  <= '0;
            raised_reg   <= '0;
            scan_idx_reg <= '0;
            cmd_reg      <= CMD_TICK;
            ch_reg       <= '0;
            ch_ok_reg    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_seen_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            cmd_reg      <= cmd_t'(command);
            ch_reg       <= in_idx;
            ch_ok_reg    <= in_ch_ok;
            raised_reg   <= '0;
            scan_idx_reg <= '0;
            case (command)
                CMD_TICK:
                begin
                    now_reg <= now_reg + 1'b1;
                end
                CMD_RECEIVE:
                begin
                    if (in_ch_ok)
                    begin
                        last_seen_reg[in_idx] <= now_reg;
                        faulted_reg[in_idx]   <= 1'b0;
                    end
                end
                CMD_CLEAR_ONE:
                begin
                    if (in_ch_ok)
                    begin
                        faulted_reg[in_idx] <= 1'b0;
                    end
                end
                CMD_CLEAR_ALL:
                begin
                    faulted_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_SCAN)
        begin
            // Raise a fault that is newly past its timeout
            if (cmp.expired && !faulted_reg[scan_idx_reg])
            begin
                faulted_reg[scan_idx_reg] <= 1'b1;
                raised_reg[scan_idx_reg]  <= 1'b1;
            end
            if (!scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // Load the result register and drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            fault_mask_reg      <= MASK_W'(faulted_reg);
            new_faults_reg      <= (cmd_reg == CMD_CHECK) ? MASK_W'(raised_reg) : '0;
            channel_faulted_reg <= ch_ok_reg && faulted_reg[ch_reg];
        end
    end

    assign out_valid       = out_valid_reg;
    assign fault_mask      = fault_mask_reg;
    assign new_faults      = new_faults_reg;
    assign channel_faulted = channel_faulted_reg;

    // A new fault always shows in the mask of the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((new_faults & ~fault_mask) == '0))
    else $error("new_faults bit set without matching fault_mask bit");

    // No request enters while a check is stepping through the channels
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> in_stall)
    else $error("request accepted during a check");

    // A result loaded from the sequencer always raises out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> out_valid)
    else $error("result load lost");

    // Only a check may report raised faults
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && (cmd_reg != CMD_CHECK)) |=> (new_faults == '0))
    else $error("new_faults reported for a command other than check");

endmodule : multi_channel_message_timeout_watchdog

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the multi-channel message timeout watchdog
// Sends command requests through the valid/stall input, predicts every
// result with a behavioral watchdog kept in step with the timeouts written,
// and compares each result field by field, in order, under random idling
// on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import mctw_pkg::*;

    localparam int unsigned CHANNEL_COUNT = 8;
    localparam int unsigned IDLE_PERCENT  = 18;
    localparam int unsigned PHASE_ITEMS   = 175;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 20;

    typedef struct {
        cmd_t              op;
        logic [CHAN_W-1:0] ch;
    } request_t;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] raised;
        logic              flag;
    } watch_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TMO_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command = '0;
    logic [CHAN_W-1:0]    channel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MASK_W-1:0]    fault_mask;
    logic [MASK_W-1:0]    new_faults;
    logic                 channel_faulted;

    // Behavioral copy of the watchdog
    logic [TIME_W-1:0]    ms_clock;
    logic [TIME_W-1:0]    stamp_ms [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] fault_flag;
    logic [TMO_W-1:0]     limit_ms [CHANNEL_COUNT];

    request_t      request_q [$];
    watch_result_t result_q [$];

    logic req_taken = 1'b0;
    int   cycle_count = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   mismatch_count = 0;
    logic calm;

    multi_channel_message_timeout_watchdog #(
        .CHANNELS(CHANNEL_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .channel(channel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fault_mask(fault_mask),
        .new_faults(new_faults),
        .channel_faulted(channel_faulted)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // No idling on either side inside this window
    assign calm = (cycle_count >= 2500) && (cycle_count < 4500);

    // Apply one command to the watchdog copy and return the result it gives
    function automatic watch_result_t advance_watchdog(cmd_t op, logic [CHAN_W-1:0] ch);
        watch_result_t res;
        logic [TIME_W-1:0] elapsed;
        bit ch_ok;
        ch_ok = (ch < CHANNEL_COUNT);
        res.raised = '0;
        case (op)
            CMD_TICK:
            begin
                ms_clock = ms_clock + 1;
            end
            CMD_CHECK:
            begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                begin
                    elapsed = ms_clock - stamp_ms[i];
                    if (elapsed > {16'd0, limit_ms[i]} && !fault_flag[i])
                    begin
                        fault_flag[i] = 1'b1;
                        res.raised[i] = 1'b1;
                    end
                end
            end
            CMD_RECEIVE:
            begin
                if (ch_ok)
                begin
                    stamp_ms[ch] = ms_clock;
                    fault_flag[ch] = 1'b0;
                end
            end
            CMD_CLEAR_ONE:
            begin
                if (ch_ok)
                    fault_flag[ch] = 1'b0;
            end
            CMD_CLEAR_ALL:
            begin
                fault_flag = '0;
            end
            default:
            begin
            end
        endcase
        res.mask = '0;
        res.mask[CHANNEL_COUNT-1:0] = fault_flag;
        res.flag = ch_ok && fault_flag[ch];
        return res;
    endfunction

    function automatic request_t random_request();
        request_t req;
        int roll;
        roll = $urandom_range(99);
        req.ch = CHAN_W'($urandom_range(7));
        if (roll < 40)
            req.op = CMD_TICK;
        else if (roll < 60)
            req.op = CMD_CHECK;
        else if (roll < 80)
            req.op = CMD_RECEIVE;
        else if (roll < 88)
            req.op = CMD_CLEAR_ONE;
        else if (roll < 92)
            req.op = CMD_CLEAR_ALL;
        else
            req.op = cmd_t'($urandom_range(7, 5));
        return req;
    endfunction

    task automatic push_request(cmd_t op, int ch);
        request_t req;
        req.op = op;
        req.ch = CHAN_W'(ch);
        request_q.push_back(req);
    endtask

    // Wait until every request went in and every result came back
    task automatic wait_drained();
        while (request_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(int idx, logic [TMO_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= value;
        limit_ms[idx] = value;
    endtask

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Request driver: advance to the next pending request once the last one went in
    always @(negedge clk)
    begin : drive_requests
        request_t req;
        if (rst_n && (!in_valid || req_taken))
        begin
            if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                req = request_q.pop_front();
                in_valid <= 1'b1;
                command <= req.op;
                channel <= req.ch;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, started once while a full phase is still queued
    always @(negedge clk)
    begin
        if (!hold_done && rst_n && request_q.size() > 100)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result receiver stall
    always @(negedge clk)
    begin
        if (hold_left != 0)
            out_stall <= 1'b1;
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Monitor: check finished results, predict accepted requests
    always @(posedge clk)
    begin : watch_ports
        watch_result_t want;
        cycle_count <= cycle_count + 1;
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result mask=%h new=%h flag=%b",
                        fault_mask, new_faults, channel_faulted));
                end
                else
                begin
                    want = result_q.pop_front();
                    if (fault_mask !== want.mask)
                        note_mismatch($sformatf("fault_mask exp %h got %h",
                            want.mask, fault_mask));
                    if (new_faults !== want.raised)
                        note_mismatch($sformatf("new_faults exp %h got %h",
                            want.raised, new_faults));
                    if (channel_faulted !== want.flag)
                        note_mismatch($sformatf("channel_faulted exp %b got %b",
                            want.flag, channel_faulted));
                end
            end
            if (in_valid && !in_stall)
                result_q.push_back(advance_watchdog(cmd_t'(command), channel));
        end
    end

    // Stimulus
    initial
    begin
        logic [TMO_W-1:0] value;
        ms_clock = '0;
        fault_flag = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            stamp_ms[i] = '0;
            limit_ms[i] = TIMEOUT_RESET;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset timeouts: nothing can expire yet
        push_request(CMD_CHECK, 0);
        push_request(CMD_TICK, 7);
        push_request(CMD_CHECK, 3);
        wait_drained();
        repeat (4) @(negedge clk);

        // Directed: zero timeouts, short ones and the maximum
        write_timeout(0, 16'd0);
        write_timeout(1, 16'd1);
        write_timeout(2, 16'd2);
        write_timeout(3, 16'd3);
        write_timeout(4, 16'hFFFF);
        write_timeout(5, 16'd5);
        write_timeout(6, 16'd0);
        write_timeout(7, 16'hFFFF);
        @(negedge clk);
        cfg_we <= 1'b0;

        push_request(CMD_CHECK, 0);
        push_request(CMD_TICK, 0);
        push_request(CMD_CHECK, 6);
        push_request(CMD_CHECK, 0);
        push_request(CMD_RECEIVE, 0);
        push_request(CMD_CLEAR_ONE, 6);
        push_request(CMD_TICK, 1);
        push_request(CMD_TICK, 2);
        push_request(CMD_CHECK, 1);
        push_request(CMD_CLEAR_ONE, 2);
        push_request(CMD_TICK, 3);
        push_request(CMD_CHECK, 3);
        push_request(cmd_t'(3'd5), 1);
        push_request(cmd_t'(3'd6), 2);
        push_request(cmd_t'(3'd7), 7);
        push_request(CMD_CLEAR_ALL, 0);
        push_request(CMD_RECEIVE, 7);
        push_request(CMD_RECEIVE, 4);
        push_request(CMD_CHECK, 5);
        push_request(CMD_TICK, 5);
        push_request(CMD_TICK, 4);
        push_request(CMD_CHECK, 5);
        push_request(CMD_CLEAR_ONE, 7);

        // Random phases, each under its own set of timeouts
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            repeat (4) @(negedge clk);
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                case (phase)
                    0: value = 16'hFFFF;
                    1: value = 16'h0000;
                    2: value = TMO_W'($urandom_range(20));
                    3: value = TMO_W'($urandom_range(60));
                    4: value = (i < 2) ? 16'($urandom_range(65535)) : TIMEOUT_RESET;
                    default: value = TMO_W'($urandom_range(10));
                endcase
                write_timeout(i, value);
            end
            @(negedge clk);
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                request_q.push_back(random_request());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[multi_channel_message_timeout_watchdog] OK");
        else
            $display("[multi_channel_message_timeout_watchdog] ERROR");
        $finish;
    end

    // Watchdog on the run itself
    initial
    begin
        #3000000;
        $display("[multi_channel_message_timeout_watchdog] ERROR");
        $finish;
    end

endmodule : testbench
